// File: rtl/tpc_pkg.sv
// Shared constants and types for the two-point temperature calibration pipeline.
`default_nettype none

package tpc_pkg;

  // Fraction bits of the result; the calibration temperatures carry three.
  localparam int RESULT_FRAC_BITS = 6;
  localparam int SCALE_SH         = RESULT_FRAC_BITS - 3;

  // Field widths fixed by the interface.
  localparam int CNT_W   = 16;          // raw and calibration counts
  localparam int OUT_W   = 16;          // result width
  localparam int BYTE_W  = 8;
  localparam int MSBS_W  = 4;
  localparam int T_W     = 10;          // assembled calibration temperature

  // Internal arithmetic widths.
  localparam int D_W     = CNT_W + 1;   // difference of two counts
  localparam int DT_W    = T_W + 1;     // difference of two temperatures
  localparam int A_W     = T_W + SCALE_SH;  // first temperature in result units
  localparam int P1_W    = A_W + 1 + D_W;
  localparam int P2_W    = D_W + DT_W;
  localparam int NUM_W   = ((P1_W > P2_W + SCALE_SH) ? P1_W : P2_W + SCALE_SH) + 1;
  localparam int DV_W    = CNT_W;       // divisor magnitude

  // Divider: a fixed number of quotient bits per stage, quotient padded to fit.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int Q_W        = DIV_STAGES * DIV_STEPS;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_TEMP_BYTE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TEMP_BYTE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MSBS      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_COUNT      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COUNT     = CFG_IDX_W'(4);

  // Assembled calibration points.
  typedef struct packed {
    logic [T_W-1:0]   t0;
    logic [T_W-1:0]   t1;
    logic [CNT_W-1:0] c0;
    logic [CNT_W-1:0] c1;
  } cal_t;

  // State of one item as it moves through the divider stages.
  typedef struct packed {
    logic [Q_W-1:0]  rq;     // dividend bits shifting out, quotient bits shifting in
    logic [DV_W-1:0] rem;    // partial remainder
    logic [DV_W-1:0] dv;     // divisor magnitude
    logic            q_neg;  // quotient sign
    logic            zero;   // calibration counts equal
    logic [A_W-1:0]  a0;     // first temperature in result units
  } div_t;

endpackage

`default_nettype wire

// File: rtl/temperature_two_point_calibration.sv
// Top level of the two-point temperature calibration block.
`default_nettype none

// Converts a signed raw sensor count to degrees Celsius in 1/64 degree units by
// straight-line interpolation through two calibration points held in registers.
// The block accepts one sample per clock cycle unless a stalled output backs it up,
// and keeps no state between samples. From input transfer onward, one stage forms
// the differences, one the two products, one the numerator and the magnitudes,
// DIV_STAGES stages run the restoring divider at four quotient bits per stage,
// and the last stage applies sign and saturation and holds the result. Each stage
// has its own valid bit and takes a new item whenever it is empty or its content
// moves on, so a stalled output only backs up the pipeline once every stage is
// full. The quotient is truncated toward zero; results outside the signed 16-bit
// range are clamped and flagged by saturated_o. When both calibration counts are
// equal no division is made: the first calibration temperature is returned and
// span_zero_o is set. Calibration registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; indexes beyond the last register are ignored, and
// writes are meant to happen only while no transfer is in progress.

module temperature_two_point_calibration import tpc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [CNT_W-1:0] raw_count_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] temp_c_x64_o,
  output logic                    saturated_o,
  output logic                    span_zero_o
);

  // Three front stages, the divider stages and the output stage.
  localparam int NST = 4 + DIV_STAGES;

  // Calibration registers, reset to zero.
  logic [BYTE_W-1:0] low_byte_q, high_byte_q;
  logic [MSBS_W-1:0] msbs_q;
  logic [CNT_W-1:0]  c0_q, c1_q;
  cal_t              cal;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_byte_q  <= '0;
      high_byte_q <= '0;
      msbs_q      <= '0;
      c0_q        <= '0;
      c1_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_TEMP_BYTE:  low_byte_q  <= cfg_data_i[BYTE_W-1:0];
        REG_HIGH_TEMP_BYTE: high_byte_q <= cfg_data_i[BYTE_W-1:0];
        REG_TEMP_MSBS:      msbs_q      <= cfg_data_i[MSBS_W-1:0];
        REG_LOW_COUNT:      c0_q        <= cfg_data_i[CNT_W-1:0];
        REG_HIGH_COUNT:     c1_q        <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Each calibration temperature takes two high bits from the shared register.
  assign cal.t0 = {msbs_q[1:0], low_byte_q};
  assign cal.t1 = {msbs_q[3:2], high_byte_q};
  assign cal.c0 = c0_q;
  assign cal.c1 = c1_q;

  // Valid bits and per-stage ready. A stage loads when it is empty or when the
  // stage after it loads; the output stage loads when empty or taken.
  logic [NST-1:0] valid_d, valid_q;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !valid_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NST; k++) begin
      valid_d[k] = rdy[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NST-1];

  // Datapath.
  div_t chain [DIV_STAGES+1];

  tpc_front u_front (
    .clk_i       (clk_i),
    .en_i        (rdy[2:0]),
    .raw_count_i (raw_count_i),
    .cal_i       (cal),
    .div_o       (chain[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tpc_div_stage u_div (
      .clk_i (clk_i),
      .en_i  (rdy[3+g]),
      .div_i (chain[g]),
      .div_o (chain[g+1])
    );
  end

  tpc_out u_out (
    .clk_i        (clk_i),
    .en_i         (rdy[NST-1]),
    .div_i        (chain[DIV_STAGES]),
    .temp_c_x64_o (temp_c_x64_o),
    .saturated_o  (saturated_o),
    .span_zero_o  (span_zero_o)
  );

`ifndef ASSERT_OFF
  // The input side only stalls when the whole pipeline is backed up by the output.
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled output");

  // A clamped result sits on one of the range limits.
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (temp_c_x64_o == 16'sh7fff || temp_c_x64_o == -16'sh8000))
    else $error("saturated result not at a range limit");

  // With equal calibration counts the result is the first temperature, never negative.
  a_zero_span_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && span_zero_o) |-> !temp_c_x64_o[OUT_W-1])
    else $error("negative result with equal calibration counts");
`endif

endmodule

`default_nettype wire

// File: rtl/tpc_front.sv
// Front end: differences, products and dividend/divisor magnitudes over three stages.
`default_nettype none

module tpc_front import tpc_pkg::*; (
  input  logic                    clk_i,
  input  logic [2:0]              en_i,
  input  logic signed [CNT_W-1:0] raw_count_i,
  input  cal_t                    cal_i,
  output div_t                    div_o
);

  typedef struct packed {
    logic [D_W-1:0]  d;
    logic [D_W-1:0]  dr;
    logic [DT_W-1:0] dt;
    logic [A_W-1:0]  a;
    logic            zero;
  } s1_t;

  typedef struct packed {
    logic [P1_W-1:0] p1;
    logic [P2_W-1:0] p2;
    logic [D_W-1:0]  d;
    logic [A_W-1:0]  a;
    logic            zero;
  } s2_t;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  div_t s3_d, s3_q;

  // Stage one: count and temperature differences.
  always_comb begin
    logic signed [D_W-1:0]  c0_s, c1_s, raw_s;
    logic signed [DT_W-1:0] t0_s, t1_s;
    c0_s  = D_W'($signed(cal_i.c0));
    c1_s  = D_W'($signed(cal_i.c1));
    raw_s = D_W'(raw_count_i);
    t0_s  = $signed({1'b0, cal_i.t0});
    t1_s  = $signed({1'b0, cal_i.t1});
    s1_d.d    = c1_s - c0_s;
    s1_d.dr   = raw_s - c0_s;
    s1_d.dt   = t1_s - t0_s;
    s1_d.a    = A_W'(cal_i.t0) << SCALE_SH;
    s1_d.zero = (cal_i.c1 == cal_i.c0);
  end

  // Stage two: the two products of the numerator.
  always_comb begin
    logic signed [A_W:0]    a_s;
    logic signed [D_W-1:0]  d_s, dr_s;
    logic signed [DT_W-1:0] dt_s;
    logic signed [P1_W-1:0] p1;
    logic signed [P2_W-1:0] p2;
    a_s  = $signed({1'b0, s1_q.a});
    d_s  = $signed(s1_q.d);
    dr_s = $signed(s1_q.dr);
    dt_s = $signed(s1_q.dt);
    p1   = a_s * d_s;
    p2   = dr_s * dt_s;
    s2_d.p1   = p1;
    s2_d.p2   = p2;
    s2_d.d    = s1_q.d;
    s2_d.a    = s1_q.a;
    s2_d.zero = s1_q.zero;
  end

  // Stage three: numerator sum, then sign and magnitude of dividend and divisor.
  always_comb begin
    logic signed [NUM_W-1:0] num;
    logic signed [D_W-1:0]   d_s;
    logic [NUM_W-1:0]        num_mag;
    logic [D_W-1:0]          d_mag;
    d_s     = $signed(s2_q.d);
    num     = NUM_W'($signed(s2_q.p1)) + (NUM_W'($signed(s2_q.p2)) <<< SCALE_SH);
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    d_mag   = d_s[D_W-1] ? D_W'(-d_s) : D_W'(d_s);
    s3_d.rq    = Q_W'(num_mag);
    s3_d.rem   = '0;
    s3_d.dv    = d_mag[DV_W-1:0];
    s3_d.q_neg = num[NUM_W-1] ^ d_s[D_W-1];
    s3_d.zero  = s2_q.zero;
    s3_d.a0    = s2_q.a;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q <= s1_d;
    end
    if (en_i[1]) begin
      s2_q <= s2_d;
    end
    if (en_i[2]) begin
      s3_q <= s3_d;
    end
  end

  assign div_o = s3_q;

endmodule

`default_nettype wire

// File: rtl/tpc_div_stage.sv
// One stage of the restoring divider, producing a fixed number of quotient bits.
`default_nettype none

module tpc_div_stage import tpc_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t div_i,
  output div_t div_o
);

  div_t div_d, div_q;

  always_comb begin
    logic [DV_W:0] tr;
    logic          qb;
    div_d = div_i;
    for (int j = 0; j < DIV_STEPS; j++) begin
      tr = {div_d.rem, div_d.rq[Q_W-1]};
      if (tr >= {1'b0, div_d.dv}) begin
        tr = tr - {1'b0, div_d.dv};
        qb = 1'b1;
      end else begin
        qb = 1'b0;
      end
      div_d.rem = tr[DV_W-1:0];
      div_d.rq  = {div_d.rq[Q_W-2:0], qb};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

`default_nettype wire

// File: rtl/tpc_out.sv
// Output stage: sign, equal-count fallback and saturation to the result range.
`default_nettype none

module tpc_out import tpc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  div_t                    div_i,
  output logic signed [OUT_W-1:0] temp_c_x64_o,
  output logic                    saturated_o,
  output logic                    span_zero_o
);

  logic [OUT_W-1:0] temp_d, temp_q;
  logic             sat_d, sat_q;
  logic             zero_q;

  always_comb begin
    logic [Q_W-1:0] mag;
    logic [Q_W-1:0] lim;
    logic           neg;
    mag = div_i.zero ? Q_W'(div_i.a0) : div_i.rq;
    neg = !div_i.zero && div_i.q_neg;
    lim = neg ? Q_W'(2 ** (OUT_W - 1)) : Q_W'(2 ** (OUT_W - 1) - 1);
    sat_d = (mag > lim);
    if (sat_d) begin
      temp_d = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else if (neg) begin
      temp_d = -mag[OUT_W-1:0];
    end else begin
      temp_d = mag[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      temp_q <= temp_d;
      sat_q  <= sat_d;
      zero_q <= div_i.zero;
    end
  end

  assign temp_c_x64_o = $signed(temp_q);
  assign saturated_o  = sat_q;
  assign span_zero_o  = zero_q;

endmodule

`default_nettype wire
